### src/hpe_pkg.sv
// Shared types and constants for the Horner polynomial evaluator.
`default_nettype none

package hpe_pkg;

    // Number format: signed fixed point with FRAC_BITS fraction bits in one word.
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int FRAC_BITS = 16;

    // Polynomial degree actually evaluated; it uses every one of the NUM_COEF coefficients.
    localparam int DEGREE    = 7;
    localparam int NUM_COEF  = 8;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    localparam int CFG_IDX_W = COEF_IDX_W + 1;

    // Each Horner step has a multiply stage and a shift/clamp/add stage.
    localparam int STEP_LAT  = 2;
    localparam int LATENCY   = STEP_LAT * DEGREE;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Control that travels alongside each word through the pipeline.
    typedef struct packed {
        logic valid;
        logic sat;
    } t_ctl;

endpackage

`default_nettype wire

### src/hpe_coef_regs.sv
// Coefficient register file written through the configuration channel.
`default_nettype none

module hpe_coef_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [hpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hpe_pkg::WORD_W-1:0]    i_cfg_data,
    output hpe_pkg::t_word                     o_coef [hpe_pkg::NUM_COEF]
);

    hpe_pkg::t_word r_coef [hpe_pkg::NUM_COEF];
    logic           w_hit;

    // Writes beyond the register list are dropped.
    assign w_hit = i_cfg_valid
                   && (i_cfg_index < hpe_pkg::CFG_IDX_W'(hpe_pkg::NUM_COEF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpe_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_hit) begin
            r_coef[i_cfg_index[hpe_pkg::COEF_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

### src/hpe_step.sv
// One Horner step: multiply, floor shift, clamp, add coefficient, clamp; two register stages.
`default_nettype none

module hpe_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hpe_pkg::t_ctl  i_ctl,
    input  wire hpe_pkg::t_word i_acc,
    input  wire hpe_pkg::t_word i_x,
    input  wire hpe_pkg::t_word i_coef,
    output hpe_pkg::t_ctl       o_ctl,
    output hpe_pkg::t_word      o_acc,
    output hpe_pkg::t_word      o_x
);

    // Stage A: full product.
    hpe_pkg::t_ctl  r_ctl_a;
    hpe_pkg::t_prod r_prod;
    hpe_pkg::t_word r_x_a;

    // Stage B: accumulated value.
    hpe_pkg::t_ctl  r_ctl_b;
    hpe_pkg::t_word r_acc_b;
    hpe_pkg::t_word r_x_b;

    hpe_pkg::t_prod               w_shift;
    logic                         w_pos_ovf;
    logic                         w_neg_ovf;
    hpe_pkg::t_word               w_p;
    logic signed [hpe_pkg::WORD_W:0] w_sum;
    logic                         w_add_ovf;
    hpe_pkg::t_word               n_acc;
    hpe_pkg::t_ctl                n_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
        end else begin
            r_ctl_a <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= hpe_pkg::t_prod'(i_acc) * hpe_pkg::t_prod'(i_x);
        r_x_a  <= i_x;
    end

    always_comb begin
        // Arithmetic shift rounds toward minus infinity.
        w_shift   = r_prod >>> hpe_pkg::FRAC_BITS;
        w_pos_ovf = !w_shift[hpe_pkg::PROD_W-1]
                    && (|w_shift[hpe_pkg::PROD_W-2:hpe_pkg::WORD_W-1]);
        w_neg_ovf = w_shift[hpe_pkg::PROD_W-1]
                    && !(&w_shift[hpe_pkg::PROD_W-2:hpe_pkg::WORD_W-1]);
        if (w_pos_ovf) begin
            w_p = hpe_pkg::WORD_MAX;
        end else if (w_neg_ovf) begin
            w_p = hpe_pkg::WORD_MIN;
        end else begin
            w_p = w_shift[hpe_pkg::WORD_W-1:0];
        end

        w_sum     = {w_p[hpe_pkg::WORD_W-1], w_p}
                    + {i_coef[hpe_pkg::WORD_W-1], i_coef};
        w_add_ovf = w_sum[hpe_pkg::WORD_W] != w_sum[hpe_pkg::WORD_W-1];
        if (w_add_ovf) begin
            n_acc = w_sum[hpe_pkg::WORD_W] ? hpe_pkg::WORD_MIN : hpe_pkg::WORD_MAX;
        end else begin
            n_acc = w_sum[hpe_pkg::WORD_W-1:0];
        end

        n_ctl.valid = r_ctl_a.valid;
        n_ctl.sat   = r_ctl_a.sat || w_pos_ovf || w_neg_ovf || w_add_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_b <= '0;
        end else begin
            r_ctl_b <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_b <= n_acc;
        r_x_b   <= r_x_a;
    end

    assign o_ctl = r_ctl_b;
    assign o_acc = r_acc_b;
    assign o_x   = r_x_b;

endmodule

`default_nettype wire

### src/horner_polynomial_eval.sv
// Top level of the pipelined Horner polynomial evaluator.
`default_nettype none

// The block evaluates value = coef0 + x*(coef1 + x*(coef2 + ... + coef7*x)) on signed
// Q16.16 words. Every product keeps its full 64 bits, is floored to Q16.16 by an
// arithmetic right shift and clamped to 32 bits; every addition of a coefficient is
// clamped as well, and o_saturated reports whether any clamp fired for that word.
// A word is taken at each rising edge where start is high and busy is low. The block
// is a pipeline of seven Horner steps, each with one register stage for the 32x32
// multiply and one for the shift, clamp and add, so busy never rises: a new word may
// enter every cycle, and its result leaves the last step's add register with o_valid
// high for one cycle. The receiver cannot stall the output, and none is needed since
// the pipeline never stops. Coefficients are written through the configuration
// channel (index 0 to 7 for coef0 to coef7, higher indexes ignored); o_cfg_ready is
// always high. Write coefficients only while no word is in flight, since every
// pipeline stage reads the live coefficient registers.

module horner_polynomial_eval (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic signed [hpe_pkg::WORD_W-1:0] i_sample,
    output      logic                          o_valid,
    output      logic signed [hpe_pkg::WORD_W-1:0] o_value,
    output      logic                          o_saturated,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [hpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hpe_pkg::WORD_W-1:0]    i_cfg_data
);

    hpe_pkg::t_word w_coef [hpe_pkg::NUM_COEF];

    // Pipeline links between steps: entry 0 feeds the first step.
    hpe_pkg::t_ctl  w_ctl [hpe_pkg::DEGREE+1];
    hpe_pkg::t_word w_acc [hpe_pkg::DEGREE+1];
    hpe_pkg::t_word w_x   [hpe_pkg::DEGREE+1];

    // The pipeline never holds, so the block is always able to take a word.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    hpe_coef_regs u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (w_coef)
    );

    // The accumulator starts as the highest-degree coefficient.
    assign w_ctl[0].valid = start && !busy;
    assign w_ctl[0].sat   = 1'b0;
    assign w_acc[0]       = w_coef[hpe_pkg::DEGREE];
    assign w_x[0]         = i_sample;

    for (genvar k = 0; k < hpe_pkg::DEGREE; k++) begin : g_step
        hpe_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .i_acc   (w_acc[k]),
            .i_x     (w_x[k]),
            .i_coef  (w_coef[hpe_pkg::DEGREE-1-k]),
            .o_ctl   (w_ctl[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_x     (w_x[k+1])
        );
    end

    // The last step's registers drive the result ports directly.
    assign o_valid     = w_ctl[hpe_pkg::DEGREE].valid;
    assign o_saturated = w_ctl[hpe_pkg::DEGREE].sat;
    assign o_value     = w_acc[hpe_pkg::DEGREE];

    // A result only leaves for a word that was taken a full pipeline depth earlier.
    a_result_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, hpe_pkg::LATENCY))
        else $error("result strobe without a word taken at the matching cycle");

    // A saturation seen before the last step must survive to the output.
    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(w_ctl[hpe_pkg::DEGREE-1].valid
                          && w_ctl[hpe_pkg::DEGREE-1].sat, hpe_pkg::STEP_LAT))
        |-> o_saturated)
        else $error("saturation flag lost in the last Horner step");

    // A valid word taken at the input must reach the output of the first step.
    a_valid_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_ctl[0].valid, hpe_pkg::STEP_LAT) && $past(i_rst_n, hpe_pkg::STEP_LAT)
        && $past(i_rst_n) |-> w_ctl[1].valid)
        else $error("word dropped between the input and the first step output");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined Horner polynomial evaluator.

module tb_top;

    import hpe_pkg::*;

    // The run is bounded by this many clock cycles.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_WORDS = 1525;
    localparam int          IDLE_PERCENT = 19;

    // Register indexes that lie past the coefficient list; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = CFG_IDX_W'(NUM_COEF);
    localparam logic [CFG_IDX_W-1:0] IDX_TOP      = '1;

    // Q16.16 constants used by the directed part.
    localparam t_word ONE      = t_word'(32'sh0001_0000);
    localparam t_word HALF     = t_word'(32'sh0000_8000);
    localparam t_word ONE_HALF = t_word'(32'sh0001_8000);

    typedef enum logic [1:0] {
        ITEM_SAMPLE,
        ITEM_COEF_WRITE,
        ITEM_DRAIN
    } t_item_kind;

    // One entry of the stimulus plan. A drain entry holds the driver back until every
    // expected word has come out, so that coefficient writes only land on an idle block.
    typedef struct {
        t_item_kind             kind;
        t_word                  sample;
        logic [CFG_IDX_W-1:0]   index;
        logic [WORD_W-1:0]      data;
        bit                     calm;
    } t_stim_item;

    typedef struct {
        t_word value;
        logic  sat;
    } t_poly_result;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    t_word                  i_sample    = '0;
    logic                   o_valid;
    t_word                  o_value;
    logic                   o_saturated;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [WORD_W-1:0]      i_cfg_data  = '0;

    t_stim_item     pending_q[$];
    t_poly_result   expected_q[$];
    int             error_count = 0;

    // Shadow of the coefficient registers, updated as each write is accepted.
    t_word          coef_shadow[NUM_COEF];
    // Coefficient set that the plan is about to load, and the no-idle marker for new items.
    t_word          plan_coef[NUM_COEF];
    bit             plan_calm = 1'b0;

    horner_polynomial_eval i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp a wide intermediate to the 32-bit word range, noting whether it clipped.
    function automatic longint clamp_word(input longint v, inout logic sat);
        if (v > longint'(WORD_MAX)) begin
            sat = 1'b1;
            return longint'(WORD_MAX);
        end
        if (v < longint'(WORD_MIN)) begin
            sat = 1'b1;
            return longint'(WORD_MIN);
        end
        return v;
    endfunction

    // Horner evaluation on the shadow coefficients. The product of two words fits in
    // 64 bits, and an arithmetic right shift of it is exactly the floor the block takes.
    function automatic t_poly_result horner_eval(input t_word x);
        longint         acc;
        longint         prod;
        int             k;
        t_poly_result   r;
        r.sat = 1'b0;
        acc = longint'(coef_shadow[DEGREE]);
        for (k = DEGREE - 1; k >= 0; k--) begin
            prod = (acc * longint'(x)) >>> FRAC_BITS;
            prod = clamp_word(prod, r.sat);
            acc  = clamp_word(prod + longint'(coef_shadow[k]), r.sat);
        end
        r.value = t_word'(acc);
        return r;
    endfunction

    task automatic push_sample(input t_word x);
        t_stim_item it;
        it.kind   = ITEM_SAMPLE;
        it.sample = x;
        it.index  = '0;
        it.data   = '0;
        it.calm   = plan_calm;
        pending_q.push_back(it);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        t_stim_item it;
        it.kind   = ITEM_COEF_WRITE;
        it.sample = '0;
        it.index  = idx;
        it.data   = data;
        it.calm   = plan_calm;
        pending_q.push_back(it);
    endtask

    task automatic push_drain();
        t_stim_item it;
        it.kind   = ITEM_DRAIN;
        it.sample = '0;
        it.index  = '0;
        it.data   = '0;
        it.calm   = 1'b1;
        pending_q.push_back(it);
    endtask

    // Wait for the pipeline to empty, then write all eight coefficients from plan_coef.
    task automatic push_coef_set();
        int k;
        push_drain();
        for (k = 0; k < NUM_COEF; k++) begin
            push_write(CFG_IDX_W'(k), plan_coef[k]);
        end
    endtask

    task automatic plan_fill(input t_word c);
        int k;
        for (k = 0; k < NUM_COEF; k++) begin
            plan_coef[k] = c;
        end
    endtask

    // Coefficients: mostly modest magnitudes so that results stay in range, with
    // zeros, the word extremes and full-range noise mixed in.
    function automatic t_word rand_coef();
        case ($urandom_range(0, 11))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return t_word'($urandom);
            3:       return '0;
            default: return t_word'(int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    // Samples: half within one unit of zero, some tiny values around zero where the
    // floor of negative products matters, plus extremes and full-range noise.
    function automatic t_word rand_sample();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return t_word'(int'($urandom_range(0, 512)) - 256);
            3, 4:    return t_word'($urandom);
            default: return t_word'(int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        endcase
    endfunction

    // Driver: presents one planned item at a time, on start or on the write channel,
    // and retires it at the edge where its handshake completes. All outputs are worked
    // out first and assigned once at the end, so a start that stays high for the next
    // word is never lowered and raised in the same step.
    always @(posedge i_clk) begin : drive
        t_stim_item             it;
        logic                   free;
        logic                   nxt_start;
        logic                   nxt_cfg_valid;
        t_word                  nxt_sample;
        logic [CFG_IDX_W-1:0]   nxt_index;
        logic [WORD_W-1:0]      nxt_data;
        nxt_start     = start;
        nxt_cfg_valid = i_cfg_valid;
        nxt_sample    = i_sample;
        nxt_index     = i_cfg_index;
        nxt_data      = i_cfg_data;
        if (!i_rst_n) begin
            nxt_start     = 1'b0;
            nxt_cfg_valid = 1'b0;
            foreach (coef_shadow[k]) coef_shadow[k] = '0;
        end else begin
            free = 1'b1;
            if (start) begin
                if (!busy) begin
                    expected_q.push_back(horner_eval(i_sample));
                    nxt_start = 1'b0;
                end else begin
                    free = 1'b0;
                end
            end
            if (i_cfg_valid) begin
                if (o_cfg_ready) begin
                    // Indexes past the list leave every coefficient as it was.
                    if (i_cfg_index < CFG_IDX_W'(NUM_COEF))
                        coef_shadow[i_cfg_index[COEF_IDX_W-1:0]] = t_word'(i_cfg_data);
                    nxt_cfg_valid = 1'b0;
                end else begin
                    free = 1'b0;
                end
            end
            if (free && pending_q.size() != 0) begin
                it = pending_q[0];
                case (it.kind)
                    ITEM_DRAIN: begin
                        if (expected_q.size() == 0)
                            void'(pending_q.pop_front());
                    end
                    ITEM_SAMPLE: begin
                        if (it.calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
                            nxt_start  = 1'b1;
                            nxt_sample = it.sample;
                            void'(pending_q.pop_front());
                        end
                    end
                    ITEM_COEF_WRITE: begin
                        if (it.calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
                            nxt_cfg_valid = 1'b1;
                            nxt_index     = it.index;
                            nxt_data      = it.data;
                            void'(pending_q.pop_front());
                        end
                    end
                    default: ;
                endcase
            end
        end
        start       <= nxt_start;
        i_cfg_valid <= nxt_cfg_valid;
        i_sample    <= nxt_sample;
        i_cfg_index <= nxt_index;
        i_cfg_data  <= nxt_data;
    end

    // Monitor: every strobed result word is matched against the oldest expectation.
    always @(posedge i_clk) begin : check
        t_poly_result want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word: value %0d saturated %0b", o_value, o_saturated);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0d, actual %0d", want.value, o_value);
                    error_count++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0b, actual %0b", want.sat, o_saturated);
                    error_count++;
                end
            end
        end
    end

    // A hang anywhere, including a word that never comes out, ends here.
    initial begin : watchdog
        int unsigned n;
        n = 0;
        while (n < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : main
        int random_done;
        int phase;
        int phase_len;
        int k;
        random_done = 0;
        phase = 0;

        // Directed part. Right after reset all coefficients are zero.
        push_sample('0);
        push_sample(WORD_MAX);
        push_sample(WORD_MIN);

        // A mixed-sign polynomial with exact binary fractions.
        plan_coef[0] = ONE;
        plan_coef[1] = -ONE;
        plan_coef[2] = HALF;
        plan_coef[3] = t_word'(-32'sh0000_4000);
        plan_coef[4] = t_word'(32'sh0002_0000);
        plan_coef[5] = t_word'(-32'sh0003_0000);
        plan_coef[6] = t_word'(32'sh0000_2000);
        plan_coef[7] = t_word'(-32'sh0000_1000);
        push_coef_set();
        push_sample('0);
        push_sample(t_word'(1));
        push_sample(t_word'(-1));
        push_sample(ONE);
        push_sample(-ONE);
        push_sample(HALF);
        push_sample(-HALF);
        push_sample(ONE_HALF);
        push_sample(WORD_MAX);
        push_sample(WORD_MIN);

        // Writes past the coefficient list must not disturb the polynomial.
        push_drain();
        push_write(IDX_PAST_END, WORD_MIN);
        push_write(IDX_TOP, $urandom);
        push_sample(ONE);
        push_sample(t_word'(-1));

        // Every coefficient at the positive extreme, then at the negative extreme.
        plan_fill(WORD_MAX);
        push_coef_set();
        push_sample(ONE);
        push_sample(-ONE);
        push_sample(WORD_MAX);
        push_sample(WORD_MIN);
        push_sample('0);
        plan_fill(WORD_MIN);
        push_coef_set();
        push_sample(ONE);
        push_sample(WORD_MIN);
        push_sample(t_word'(-1));

        // Random part: phases with a fresh coefficient set each, some shaped as the
        // degree-3 and degree-5 variants. Phase two runs with no idle cycles at all.
        while (random_done < RANDOM_WORDS) begin
            for (k = 0; k < NUM_COEF; k++) begin
                plan_coef[k] = rand_coef();
            end
            case ($urandom_range(0, 3))
                0: for (k = 4; k < NUM_COEF; k++) plan_coef[k] = '0;
                1: for (k = 6; k < NUM_COEF; k++) plan_coef[k] = '0;
                default: ;
            endcase
            plan_calm = (phase == 2);
            push_coef_set();
            if ($urandom_range(0, 3) == 0)
                push_write(CFG_IDX_W'($urandom_range(NUM_COEF, 2 ** CFG_IDX_W - 1)), $urandom);
            phase_len = $urandom_range(30, 90);
            if (phase == 2)
                phase_len = 150;
            for (k = 0; k < phase_len && random_done < RANDOM_WORDS; k++) begin
                push_sample(rand_sample());
                random_done++;
            end
            phase++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || expected_q.size() != 0 || start)
            @(posedge i_clk);
        // Let any stray word that follows the last expected one show up.
        repeat (LATENCY + 4) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
